FILE: rtl/overlapping_allan_deviation_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the overlapping Allan deviation core
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef OVERLAPPING_ALLAN_DEVIATION_CORE_ASSERT_SVH
`define OVERLAPPING_ALLAN_DEVIATION_CORE_ASSERT_SVH

// same-cycle implication
`define OADEV_ASSERT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define OADEV_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/oadev_pkg.sv
// ----------------------------------------------------------------------------
// oadev_pkg
// Shared types and constants of the overlapping Allan deviation core.
// ----------------------------------------------------------------------------
package oadev_pkg;

  localparam int SampleW = 16;
  localparam int WlW     = 9;
  localparam int DevW    = 24;
  localparam int TermW   = 17;
  localparam int AccW    = 64;
  localparam int QuoW    = 48;   // quotient S*2^16/den when it fits
  localparam int RootW   = 24;   // square root of QuoW bits
  localparam int TauSqW  = 18;   // tau*tau with tau < 512

  localparam logic [DevW-1:0] DevMax = '1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_SHORT = 2'd1,
    STATUS_SAT   = 2'd2
  } oadev_status_e;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last;
  } oadev_in_t;

  typedef struct packed {
    logic [DevW-1:0]  deviation;
    logic [TermW-1:0] term_count;
    oadev_status_e    status;
  } oadev_out_t;

  // per-sample sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_DIFF,
    ST_SQ,
    ST_ACC,
    ST_START,
    ST_WAIT
  } oadev_state_e;

  // final divide / root sequencer
  typedef enum logic [2:0] {
    R_IDLE,
    R_TSQ,
    R_DEN,
    R_CHK,
    R_DIV,
    R_SQRT,
    R_DONE
  } oadev_root_state_e;

  typedef struct packed {
    logic clear;
    logic full;
    logic upd;
    logic diff;
    logic sq;
    logic acc;
  } oadev_win_ctl_t;

endpackage

FILE: rtl/oadev_ring.sv
// ----------------------------------------------------------------------------
// oadev_ring
// Sample ring: one write port, two registered read ports, read-first.
// ----------------------------------------------------------------------------
module oadev_ring #(
  parameter int AddrW = 9
) (
  input  logic                               clk_i,
  input  logic                               wr_en_i,
  input  logic [AddrW-1:0]                   wr_addr_i,
  input  logic signed [oadev_pkg::SampleW-1:0] wr_data_i,
  input  logic                               rd_en_i,
  input  logic [AddrW-1:0]                   rd_addr_a_i,
  input  logic [AddrW-1:0]                   rd_addr_b_i,
  output logic signed [oadev_pkg::SampleW-1:0] rd_data_a_o,
  output logic signed [oadev_pkg::SampleW-1:0] rd_data_b_o
);
  import oadev_pkg::*;

  localparam int Depth = 2 ** AddrW;

  logic signed [SampleW-1:0] mem_q [Depth];
  logic signed [SampleW-1:0] rd_a_q;
  logic signed [SampleW-1:0] rd_b_q;

  // a read at the write address returns the old entry (needed when 2*tau fills the ring)
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_a_q <= mem_q[rd_addr_a_i];
      rd_b_q <= mem_q[rd_addr_b_i];
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

FILE: rtl/oadev_win.sv
// ----------------------------------------------------------------------------
// oadev_win
// Run state: two sliding window sums, squared difference accumulator,
// sample count and saturation flag.
// ----------------------------------------------------------------------------
module oadev_win #(
  parameter int CntW = 17,
  parameter int SumW = 25
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  oadev_pkg::oadev_win_ctl_t            ctl_i,
  input  logic [oadev_pkg::WlW-1:0]            tau_i,
  input  logic signed [oadev_pkg::SampleW-1:0] sample_i,
  input  logic signed [oadev_pkg::SampleW-1:0] tap_late_i,
  input  logic signed [oadev_pkg::SampleW-1:0] tap_early_i,
  output logic [CntW-1:0]                      cnt_o,
  output logic                                 sat_o,
  output logic [oadev_pkg::AccW-1:0]           acc_o
);
  import oadev_pkg::*;

  localparam int DiffW = SumW + 1;
  localparam int SqW   = 2 * DiffW;

  logic signed [SumW-1:0]  late_q, late_d;
  logic signed [SumW-1:0]  early_q, early_d;
  logic signed [DiffW-1:0] diff_q;
  logic [SqW-1:0]          sq_q;
  logic [AccW-1:0]         acc_q;
  logic [CntW-1:0]         cnt_q;
  logic                    sat_q;
  logic                    pair_q;

  logic signed [SqW-1:0]   prod;
  logic [AccW:0]           acc_sum;
  logic [31:0]             two_tau;
  logic                    ge_tau, ge_2tau, pair_d;

  always_comb begin
    two_tau = 32'(tau_i) << 1;
    ge_tau  = 32'(cnt_q) >= 32'(tau_i);
    ge_2tau = 32'(cnt_q) >= two_tau;
    pair_d  = (32'(cnt_q) + 32'd1) >= two_tau;

    late_d  = late_q + SumW'(sample_i);
    early_d = early_q;
    if (ge_tau) begin
      // sample n-tau moves from the late window into the early one
      late_d  = late_d - SumW'(tap_late_i);
      early_d = early_q + SumW'(tap_late_i);
      if (ge_2tau) begin
        early_d = early_d - SumW'(tap_early_i);
      end
    end

    prod    = diff_q * diff_q;
    acc_sum = {1'b0, acc_q} + (AccW + 1)'(sq_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      late_q  <= '0;
      early_q <= '0;
      diff_q  <= '0;
      sq_q    <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
      sat_q   <= 1'b0;
      pair_q  <= 1'b0;
    end else if (ctl_i.clear) begin
      late_q  <= '0;
      early_q <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
      sat_q   <= 1'b0;
      pair_q  <= 1'b0;
    end else begin
      if (ctl_i.full) begin
        sat_q <= 1'b1;
      end
      if (ctl_i.upd) begin
        late_q  <= late_d;
        early_q <= early_d;
        cnt_q   <= cnt_q + 1'b1;
        pair_q  <= pair_d;
      end
      if (ctl_i.diff) begin
        diff_q <= DiffW'(late_q) - DiffW'(early_q);
      end
      if (ctl_i.sq) begin
        sq_q <= $unsigned(prod);
      end
      if (ctl_i.acc && pair_q) begin
        if (acc_sum[AccW]) begin
          acc_q <= '1;
          sat_q <= 1'b1;
        end else begin
          acc_q <= acc_sum[AccW-1:0];
        end
      end
    end
  end

  assign cnt_o = cnt_q;
  assign sat_o = sat_q;
  assign acc_o = acc_q;

endmodule

FILE: rtl/oadev_root.sv
// ----------------------------------------------------------------------------
// oadev_root
// End-of-run result: den = 2*nt*tau^2, q = floor(S*2^16/den) by restoring
// division (one bit a cycle), deviation = isqrt(q) (one bit a cycle).
// ----------------------------------------------------------------------------
module oadev_root #(
  parameter int CntW = 17
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       ack_i,
  input  logic [oadev_pkg::AccW-1:0] acc_i,
  input  logic [CntW-1:0]            cnt_i,
  input  logic [oadev_pkg::WlW-1:0]  tau_i,
  input  logic                       sat_i,
  output logic                       done_o,
  output oadev_pkg::oadev_out_t      result_o
);
  import oadev_pkg::*;

  localparam int ProdW = CntW + TauSqW;
  localparam int DenW  = ProdW + 1;
  localparam int CmpW  = (DenW > 32) ? DenW : 32;
  localparam int StepW = $clog2(QuoW);

  oadev_root_state_e state_q, state_d;

  oadev_out_t         res_q;
  logic [AccW-1:0]    acc_q;
  logic [CntW-1:0]    nt_q;
  logic [WlW-1:0]     tau_q;
  logic [TauSqW-1:0]  tsq_q;
  logic [DenW-1:0]    den_q;
  logic [DenW-1:0]    rem_q;
  logic [QuoW-1:0]    wrk_q;
  logic [RootW-1:0]   root_q;
  logic [RootW+1:0]   srem_q;
  logic [StepW-1:0]   step_q;

  logic [31:0]        two_tau;
  logic               short_run;
  logic [CntW-1:0]    nt;
  logic [ProdW-1:0]   nt_tsq;
  logic               quo_ovf;
  logic [DenW:0]      div_try, div_sub;
  logic               div_ge;
  logic [RootW+1:0]   sq_try, sq_trial;
  logic               sq_ge;

  always_comb begin
    two_tau   = 32'(tau_i) << 1;
    short_run = 32'(cnt_i) < two_tau;
    nt        = CntW'(32'(cnt_i) - two_tau + 32'd1);
    nt_tsq    = ProdW'(nt_q) * ProdW'(tsq_q);
    // q >= 2^48 exactly when S/2^32 >= den
    quo_ovf   = CmpW'(acc_q[AccW-1:32]) >= CmpW'(den_q);
    div_try   = {rem_q, wrk_q[QuoW-1]};
    div_ge    = div_try >= {1'b0, den_q};
    div_sub   = div_try - {1'b0, den_q};
    sq_try    = {srem_q[RootW-1:0], wrk_q[QuoW-1 -: 2]};
    sq_trial  = {root_q, 2'b01};
    sq_ge     = sq_try >= sq_trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      R_IDLE: begin
        if (start_i) begin
          state_d = (short_run || sat_i) ? R_DONE : R_TSQ;
        end
      end
      R_TSQ: state_d = R_DEN;
      R_DEN: state_d = R_CHK;
      R_CHK: state_d = quo_ovf ? R_DONE : R_DIV;
      R_DIV: begin
        if (step_q == '0) begin
          state_d = R_SQRT;
        end
      end
      R_SQRT: begin
        if (step_q == '0) begin
          state_d = R_DONE;
        end
      end
      R_DONE: begin
        if (ack_i) begin
          state_d = R_IDLE;
        end
      end
      default: state_d = R_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      R_IDLE: begin
        if (start_i) begin
          acc_q <= acc_i;
          tau_q <= tau_i;
          nt_q  <= nt;
          if (short_run) begin
            res_q.deviation  <= '0;
            res_q.term_count <= '0;
            res_q.status     <= STATUS_SHORT;
          end else begin
            // all ones stands for saturation and quotient overflow alike
            res_q.deviation  <= DevMax;
            res_q.term_count <= TermW'(nt);
            res_q.status     <= sat_i ? STATUS_SAT : STATUS_OK;
          end
        end
      end
      R_TSQ: tsq_q <= TauSqW'(tau_q) * TauSqW'(tau_q);
      R_DEN: den_q <= {nt_tsq, 1'b0};
      R_CHK: begin
        rem_q  <= DenW'(acc_q[AccW-1:32]);
        wrk_q  <= {acc_q[31:0], 16'h0000};
        step_q <= StepW'(QuoW - 1);
      end
      R_DIV: begin
        // dividend bits shift out the top, quotient bits shift in below
        rem_q <= div_ge ? div_sub[DenW-1:0] : div_try[DenW-1:0];
        wrk_q <= {wrk_q[QuoW-2:0], div_ge};
        if (step_q == '0) begin
          srem_q <= '0;
          root_q <= '0;
          step_q <= StepW'(RootW - 1);
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
      R_SQRT: begin
        srem_q <= sq_ge ? (sq_try - sq_trial) : sq_try;
        root_q <= {root_q[RootW-2:0], sq_ge};
        wrk_q  <= wrk_q << 2;
        step_q <= step_q - 1'b1;
        if (step_q == '0) begin
          res_q.deviation <= {root_q[RootW-2:0], sq_ge};
        end
      end
      R_DONE: ;
      default: ;
    endcase
  end

  assign done_o   = (state_q == R_DONE);
  assign result_o = res_q;

endmodule

FILE: rtl/overlapping_allan_deviation_core.sv
// ----------------------------------------------------------------------------
// overlapping_allan_deviation_core
// Overlapping Allan deviation of one run of samples for a set tau.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one signed
//   16-bit sample per transaction; last marks the end of a run. The output
//   channel (out_valid_o / out_stall_i / out_data_o) gives one transaction per
//   run: deviation (8 fraction bits, truncated), term_count and status.
//   cfg_we_i writes window_length (tau) from cfg_wdata_i and clears the run;
//   write it only while the block is idle.
//   Each sample passes accept and ring read, window update, difference, square
//   and accumulate - the read-modify-write of the window sums through the ring
//   memory - before the next is taken; once the count is full, samples are dropped.
//   The result passes the tau square, denominator and overflow check, the
//   48-step divider and the 24-step square root; a quotient overflow skips the
//   divider and root, a short or saturated run goes straight to the result,
//   and a last sample that finds the count full skips the per-sample steps.
//   Reset clears the run state and sets tau to 1; the ring is not cleared.
//   A stalled result waits in the output register while the next run's
//   samples are taken; a second result waits until that register frees.
module overlapping_allan_deviation_core #(
  parameter int MAX_TAU     = 256,
  parameter int MAX_SAMPLES = 65536
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [oadev_pkg::WlW-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  oadev_pkg::oadev_in_t        in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output oadev_pkg::oadev_out_t       out_data_o
);
  import oadev_pkg::*;

  localparam int AddrW = $clog2(2 * MAX_TAU);
  localparam int CntW  = $clog2(MAX_SAMPLES + 1);
  localparam int SumW  = SampleW + 1 + $clog2(MAX_TAU);

  oadev_state_e   state_q, state_d;
  oadev_win_ctl_t win_ctl;

  logic [WlW-1:0]            wl_q;
  logic [WlW-1:0]            tau;
  logic                      last_q;
  logic signed [SampleW-1:0] y_q;
  logic                      out_valid_q;
  oadev_out_t                out_q;

  logic                      in_accept;
  logic                      cnt_full;
  logic                      ring_en;
  logic [AddrW-1:0]          wr_addr, rd_addr_late, rd_addr_early;
  logic signed [SampleW-1:0] tap_late, tap_early;
  logic [CntW-1:0]           win_cnt;
  logic                      win_sat;
  logic [AccW-1:0]           win_acc;
  logic                      root_start, root_ack, root_done;
  oadev_out_t                root_result;
  logic                      out_load;

  always_comb begin
    if (wl_q == '0) begin
      tau = WlW'(1);
    end else if (32'(wl_q) > 32'(MAX_TAU)) begin
      tau = WlW'(MAX_TAU);
    end else begin
      tau = wl_q;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign cnt_full   = win_cnt >= CntW'(MAX_SAMPLES);

  // ring index arithmetic wraps at the power-of-two ring size
  assign wr_addr       = AddrW'(win_cnt);
  assign rd_addr_late  = AddrW'(win_cnt) - AddrW'(tau);
  assign rd_addr_early = AddrW'(win_cnt) - AddrW'({tau, 1'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wl_q        <= WlW'(1);
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        wl_q <= cfg_wdata_i;
      end
      if (in_accept) begin
        last_q <= in_data_i.last;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      y_q <= in_data_i.sample;
    end
    if (out_load) begin
      out_q <= root_result;
    end
  end

  always_comb begin
    state_d       = state_q;
    win_ctl       = '0;
    win_ctl.clear = cfg_we_i;
    ring_en       = 1'b0;
    root_start    = 1'b0;
    root_ack      = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (cnt_full) begin
            // sample dropped, run marked saturated
            win_ctl.full = 1'b1;
            if (in_data_i.last) begin
              state_d = ST_START;
            end
          end else begin
            ring_en = 1'b1;
            state_d = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        win_ctl.upd = 1'b1;
        state_d     = ST_DIFF;
      end
      ST_DIFF: begin
        win_ctl.diff = 1'b1;
        state_d      = ST_SQ;
      end
      ST_SQ: begin
        win_ctl.sq = 1'b1;
        state_d    = ST_ACC;
      end
      ST_ACC: begin
        win_ctl.acc = 1'b1;
        state_d     = last_q ? ST_START : ST_IDLE;
      end
      ST_START: begin
        root_start = 1'b1;
        state_d    = ST_WAIT;
      end
      ST_WAIT: begin
        if (root_done && (!out_valid_q || !out_stall_i)) begin
          out_load      = 1'b1;
          root_ack      = 1'b1;
          win_ctl.clear = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  oadev_ring #(
    .AddrW (AddrW)
  ) u_ring (
    .clk_i       (clk_i),
    .wr_en_i     (ring_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (in_data_i.sample),
    .rd_en_i     (ring_en),
    .rd_addr_a_i (rd_addr_late),
    .rd_addr_b_i (rd_addr_early),
    .rd_data_a_o (tap_late),
    .rd_data_b_o (tap_early)
  );

  oadev_win #(
    .CntW (CntW),
    .SumW (SumW)
  ) u_win (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (win_ctl),
    .tau_i       (tau),
    .sample_i    (y_q),
    .tap_late_i  (tap_late),
    .tap_early_i (tap_early),
    .cnt_o       (win_cnt),
    .sat_o       (win_sat),
    .acc_o       (win_acc)
  );

  oadev_root #(
    .CntW (CntW)
  ) u_root (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (root_start),
    .ack_i    (root_ack),
    .acc_i    (win_acc),
    .cnt_i    (win_cnt),
    .tau_i    (tau),
    .sat_i    (win_sat),
    .done_o   (root_done),
    .result_o (root_result)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "overlapping_allan_deviation_core_assert.svh"

  `OADEV_ASSERT(a_cnt_bound, 1'b1, 32'(win_cnt) <= 32'(MAX_SAMPLES), "sample count past limit")
  `OADEV_ASSERT(a_short_zero, out_valid_o && out_data_o.status == STATUS_SHORT, out_data_o.deviation == '0 && out_data_o.term_count == '0, "short run result not zero")
  `OADEV_ASSERT(a_sat_max, out_valid_o && out_data_o.status == STATUS_SAT, out_data_o.deviation == DevMax, "saturated run deviation not all ones")
  `OADEV_ASSERT_NEXT(a_clear_after_load, out_load, win_cnt == '0 && !win_sat, "run state not cleared after result")

endmodule
